// ----- hw/rtl/chkv_pkg.sv -----
// Package with shared constants for the chained hash key/value store.
`default_nettype none
package chkv_pkg;
  localparam int BUCKETS_DEF    = 100;
  localparam int POOL_NODES_DEF = 256;
  localparam int VALUE_BITS_DEF = 32;
  localparam int HASH_MULT      = 31;
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;
endpackage
`default_nettype wire

// ----- hw/rtl/chained_hash_key_value_store.sv -----
// Top level of the chained hash key/value store.
// From accept to result strobe, insert: S_HASH, S_MOD, S_HEAD, S_INS (skipped on a full
// pool), S_DONE; search and delete: up to S_HEAD, then S_NODE and S_CHK per chain node,
// S_FREE on a delete hit, S_DONE; unused command: S_DONE. One item at a time: busy is
// low again in the strobe cycle. Reset: one clearing pass empties the bucket heads and
// fills the free stack; busy is high during it. The receiver cannot stall results.
`default_nettype none
module chained_hash_key_value_store #(
  parameter int BUCKETS    = chkv_pkg::BUCKETS_DEF,
  parameter int POOL_NODES = chkv_pkg::POOL_NODES_DEF,
  parameter int VALUE_BITS = chkv_pkg::VALUE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         cmd,
  input  wire logic [7:0]         key,
  input  wire logic signed [31:0] value,
  output logic                    done,
  output logic                    found,
  output logic signed [31:0]      result_value,
  output logic                    status
);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW = $clog2(POOL_NODES + 1);   // link width, NIL = POOL_NODES
  localparam int IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int CW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int HW = 8 + 6;
  localparam logic [NW-1:0] NIL = NW'(POOL_NODES);
  localparam int CLRN = (BUCKETS > POOL_NODES) ? BUCKETS : POOL_NODES;
  localparam int CLW  = $clog2(CLRN + 1);
  // Reciprocal of the bucket count, exact for every HW-bit dividend.
  localparam int HSH = HW + BW;
  localparam int RM  = (1 << HSH) / BUCKETS + 1;
  localparam int MW  = HW + 1;
  localparam int QW  = HW + 1 - BW;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_HEAD  = 4'd3;
  localparam logic [3:0] S_NODE  = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_INS   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;
  localparam logic [3:0] S_FREE  = 4'd8;
  localparam logic [3:0] S_MOD   = 4'd9;

  // Memories.
  logic [NW-1:0]         head_mem [BUCKETS];
  logic [7:0]            nkey_mem [POOL_NODES];
  logic [VALUE_BITS-1:0] nval_mem [POOL_NODES];
  logic [NW-1:0]         nnext_mem[POOL_NODES];
  logic [IW-1:0]         free_mem [POOL_NODES];

  logic [3:0]  state;
  logic [1:0]  op;
  logic [7:0]  okey;
  logic [31:0] oval;
  logic [HW-1:0] hsum;
  logic [QW-1:0] hq;
  logic [HW+MW-1:0] hprod;
  logic [HW-1:0] hrem;
  logic [BW-1:0] bkt;
  logic [NW-1:0] cur, prev, head_q, nnext_q;
  logic [7:0]    nkey_q;
  logic [VALUE_BITS-1:0] nval_q;
  logic [IW-1:0] free_q;
  logic [NW-1:0] fcount;
  logic [NW:0]   steps;
  logic [CLW-1:0] clr;

  // The bucket is key*31 mod BUCKETS. The quotient comes from a multiply by the
  // reciprocal and is registered in S_HASH; the remainder is formed from it in S_MOD.
  assign hprod = (HW+MW)'(hsum) * (HW+MW)'(RM);
  assign hrem  = hsum - HW'(hq) * HW'(BUCKETS);

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr   <= '0;
      fcount <= NW'(POOL_NODES);
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLR: begin
          if (clr < CLW'(BUCKETS)) head_mem[clr[BW-1:0]] <= NIL;
          if (clr < CLW'(POOL_NODES)) free_mem[clr[IW-1:0]] <= clr[IW-1:0];
          clr <= clr + 1'b1;
          if (clr == CLW'(CLRN - 1)) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          op <= cmd; okey <= key; oval <= value;
          hsum <= HW'(key) * HW'(chkv_pkg::HASH_MULT);
          if (cmd == chkv_pkg::CMD_INSERT || cmd == chkv_pkg::CMD_DELETE ||
              cmd == chkv_pkg::CMD_SEARCH) state <= S_HASH;
          else begin
            // The unused command changes nothing and answers with zeros.
            found <= 1'b0; result_value <= '0; status <= 1'b0;
            state <= S_DONE;
          end
        end
        S_HASH: begin
          hq <= hprod[HW+MW-1:HSH];
          state <= S_MOD;
        end
        S_MOD: begin
          bkt <= hrem[BW-1:0];
          head_q <= head_mem[hrem[BW-1:0]];
          free_q <= free_mem[CW'(fcount - 1'b1)];
          state <= S_HEAD;
        end
        S_HEAD: begin
          found <= 1'b0; status <= 1'b0; result_value <= '0;
          prev <= NIL; cur <= head_q; steps <= '0;
          if (op == chkv_pkg::CMD_INSERT) begin
            if (fcount == '0) begin status <= 1'b1; state <= S_DONE; end
            else state <= S_INS;
          end else begin
            if (op == chkv_pkg::CMD_SEARCH) result_value <= '1;
            state <= S_NODE;
          end
        end
        S_INS: begin
          nkey_mem[free_q]  <= okey;
          nval_mem[free_q]  <= VALUE_BITS'($signed(oval));
          nnext_mem[free_q] <= head_q;
          head_mem[bkt]     <= NW'(free_q);
          fcount <= fcount - 1'b1;
          state <= S_DONE;
        end
        S_NODE: begin
          if (cur >= NIL || steps >= (NW+1)'(POOL_NODES)) state <= S_DONE;
          else begin
            nkey_q  <= nkey_mem[cur[IW-1:0]];
            nval_q  <= nval_mem[cur[IW-1:0]];
            nnext_q <= nnext_mem[cur[IW-1:0]];
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (nkey_q == okey) begin
            found <= 1'b1;
            if (op == chkv_pkg::CMD_SEARCH) begin
              result_value <= 32'($signed(nval_q));
              state <= S_DONE;
            end else begin
              if (prev == NIL) head_mem[bkt] <= nnext_q;
              else nnext_mem[prev[IW-1:0]] <= nnext_q;
              state <= S_FREE;
            end
          end else begin
            prev <= cur; cur <= nnext_q; steps <= steps + 1'b1;
            state <= S_NODE;
          end
        end
        S_FREE: begin
          if (fcount < NW'(POOL_NODES)) begin
            free_mem[CW'(fcount)] <= cur[IW-1:0];
            fcount <= fcount + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin done <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result strobes never come back to back.
  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("double strobe");
  // The free count never exceeds the pool size.
  a_fcount: assert property (@(posedge clk) disable iff (rst) fcount <= NW'(POOL_NODES))
    else $error("free count overflow");
  // An insert refusal only happens on an empty pool.
  a_full: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (fcount == '0)) else $error("bad refusal");
endmodule
`default_nettype wire

// ----- tb/chained_hash_key_value_store_checker.sv -----
// Checker that predicts and compares every result of the chained hash key/value store.
`timescale 1ns / 100ps
module chained_hash_key_value_store_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [1:0]         cmd,
  input  wire logic [7:0]         key,
  input  wire logic signed [31:0] value,
  input  wire logic               done,
  input  wire logic               found,
  input  wire logic signed [31:0] result_value,
  input  wire logic               status,
  output int                      fail_count,
  output int                      pending
);
  localparam int NBKT = chkv_pkg::BUCKETS_DEF;
  localparam int NPOOL = chkv_pkg::POOL_NODES_DEF;
  localparam logic [8:0] NIL = 9'(NPOOL);

  typedef struct packed {
    logic        found;
    logic [31:0] rval;
    logic        status;
  } answer_t;

  logic [8:0]  heads[NBKT];
  logic [7:0]  nkey[NPOOL];
  logic [31:0] nval[NPOOL];
  logic [8:0]  nnext[NPOOL];
  logic [8:0]  free_list[NPOOL];
  int          free_n;
  answer_t     answers[$];

  function automatic answer_t apply_command(logic [1:0] c, logic [7:0] k, logic [31:0] v);
    answer_t a;
    int b;
    logic [8:0] cur, prv, n;
    a = '0;
    b = (int'(k) * chkv_pkg::HASH_MULT) % NBKT;
    if (c == chkv_pkg::CMD_INSERT) begin
      if (free_n == 0) begin
        a.status = 1'b1;
      end else begin
        free_n--;
        n = free_list[free_n];
        nkey[n] = k;
        nval[n] = v;
        nnext[n] = heads[b];
        heads[b] = n;
      end
    end else if (c == chkv_pkg::CMD_DELETE || c == chkv_pkg::CMD_SEARCH) begin
      if (c == chkv_pkg::CMD_SEARCH) a.rval = '1;
      prv = NIL;
      cur = heads[b];
      for (int s = 0; s < NPOOL && cur < NIL; s++) begin
        if (nkey[cur] == k) begin
          a.found = 1'b1;
          if (c == chkv_pkg::CMD_SEARCH) begin
            a.rval = nval[cur];
          end else begin
            if (prv == NIL) heads[b] = nnext[cur];
            else nnext[prv] = nnext[cur];
            free_list[free_n] = cur;
            free_n++;
          end
          break;
        end
        prv = cur;
        cur = nnext[cur];
      end
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t exp_a;
    if (rst) begin
      for (int i = 0; i < NBKT; i++) heads[i] = NIL;
      for (int i = 0; i < NPOOL; i++) free_list[i] = 9'(i);
      free_n = NPOOL;
      answers.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (done) begin
        if (answers.size() == 0) begin
          $display("%0t: unexpected result found=%0b value=%0d status=%0b", $time,
                   found, result_value, status);
          fail_count <= fail_count + 1;
        end else begin
          exp_a = answers.pop_front();
          if (exp_a != {found, result_value, status}) begin
            $display("%0t: expected found=%0b value=%0d status=%0b, got %0b %0d %0b",
                     $time, exp_a.found, $signed(exp_a.rval), exp_a.status,
                     found, result_value, status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) answers.push_back(apply_command(cmd, key, value));
      pending <= answers.size();
    end
  end
endmodule

// ----- tb/chained_hash_key_value_store_tb.sv -----
// Top of the testbench: clock, reset, command stimulus and the verdict.
`timescale 1ns / 100ps
module chained_hash_key_value_store_tb;
  logic clk, rst, start, busy, done, found, status;
  logic [1:0] cmd;
  logic [7:0] key;
  logic signed [31:0] value, result_value;
  int fail_count, pending;
  int idle_pct;

  chained_hash_key_value_store DUT (.*);
  chained_hash_key_value_store_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous limit for about 900 items, even on long chains.
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  // The multiples of 100 in the pool land in bucket 0: key*31 mod 100 == 0 for them.
  // Keys 0, 100 and 200 share one chain, which exercises unlink in the middle.
  logic [7:0] key_pool[8] = '{8'd0, 8'd100, 8'd200, 8'd255, 8'd1, 8'd101, 8'd201, 8'd7};

  // Presents one item and holds it until accepted; random idle gaps before it.
  // Start stays high after the accepting edge; the next item or an idle cycle
  // takes it over, and busy keeps the old item from being taken twice.
  task automatic send_item(logic [1:0] c, logic [7:0] k, logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    key <= k;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Waits until every predicted result has been seen.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly keys from a small pool so chains grow and hits are common.
  task automatic random_phase(int count);
    logic [1:0] c;
    logic [7:0] k;
    for (int i = 0; i < count; i++) begin
      c = 2'($urandom_range(3));
      k = ($urandom_range(3) != 0) ? key_pool[$urandom_range(7)] : 8'($urandom);
      send_item(c, k, $urandom);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = chkv_pkg::CMD_INSERT;
    key = '0;
    value = '0;
    idle_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: misses on an empty table, stacked duplicates, chain unlink
    // at head and in the middle, extreme values, and the unused command.
    send_item(chkv_pkg::CMD_SEARCH, 8'd0, '0);
    send_item(chkv_pkg::CMD_DELETE, 8'd255, '0);
    send_item(chkv_pkg::CMD_INSERT, 8'd0, 32'h8000_0000);
    send_item(chkv_pkg::CMD_INSERT, 8'd100, 32'h7FFF_FFFF);
    send_item(chkv_pkg::CMD_INSERT, 8'd200, 32'hFFFF_FFFF);
    send_item(chkv_pkg::CMD_INSERT, 8'd100, 32'h0000_0000);
    send_item(chkv_pkg::CMD_SEARCH, 8'd100, '0);
    send_item(chkv_pkg::CMD_DELETE, 8'd100, '0);
    send_item(chkv_pkg::CMD_SEARCH, 8'd100, '0);
    send_item(chkv_pkg::CMD_DELETE, 8'd100, '0);
    send_item(chkv_pkg::CMD_SEARCH, 8'd0, '0);
    send_item(chkv_pkg::CMD_SEARCH, 8'd200, '0);
    send_item(chkv_pkg::CMD_INSERT, 8'd255, 32'h5555_AAAA);
    send_item(chkv_pkg::CMD_SEARCH, 8'd255, '0);
    send_item(chkv_pkg::CMD_NOP, 8'd255, 32'hFFFF_FFFF);
    drain();

    // Fill the pool to overflow, check the refusal, then empty part of it.
    for (int i = 0; i < 260; i++) begin
      send_item(chkv_pkg::CMD_INSERT, 8'($urandom_range(255)), $urandom);
    end
    drain();
    for (int i = 0; i < 100; i++) send_item(chkv_pkg::CMD_DELETE, 8'($urandom_range(255)), '0);

    idle_pct = 29;
    random_phase(180);
    // Hold off until the store is quiet before changing the pacing.
    drain();
    idle_pct = 79;
    random_phase(180);
    idle_pct = 0;
    random_phase(180);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
